/* rtl/cdn_pkg.sv */
// Shared types, constants and calendar helpers for the date normalizer.
// No dependencies; every other file imports this package.
package cdn_pkg;

	localparam int MONTH_W = 4;
	localparam int DAY_IN_W = 16;
	localparam int DAY_OUT_W = 5;
	localparam int YEAR_W = 14;
	// running year may leave 0..16383 by about ninety years either way
	localparam int YEAR_RUN_W = 16;

	localparam logic [MONTH_W-1:0] MON_JAN = 4'd1;
	localparam logic [MONTH_W-1:0] MON_FEB = 4'd2;
	localparam logic [MONTH_W-1:0] MON_APR = 4'd4;
	localparam logic [MONTH_W-1:0] MON_JUN = 4'd6;
	localparam logic [MONTH_W-1:0] MON_SEP = 4'd9;
	localparam logic [MONTH_W-1:0] MON_NOV = 4'd11;
	localparam logic [MONTH_W-1:0] MON_DEC = 4'd12;

	localparam logic [DAY_OUT_W-1:0] DAYS_LONG = 5'd31;
	localparam logic [DAY_OUT_W-1:0] DAYS_SHORT = 5'd30;
	localparam logic [DAY_OUT_W-1:0] DAYS_FEB_LEAP = 5'd29;
	localparam logic [DAY_OUT_W-1:0] DAYS_FEB = 5'd28;
	localparam logic [DAY_OUT_W-1:0] DAY_FIRST = 5'd1;

	localparam logic [YEAR_W-1:0] YEAR_MAX = 14'd9999;
	localparam logic [YEAR_W-1:0] YEAR_MIN = 14'd0;
	localparam logic [YEAR_W-1:0] CYCLE_LEN = 14'd400;
	localparam logic [YEAR_W-1:0] CYCLE_LAST = 14'd399;
	localparam logic [8:0] CENTURY = 9'd100;

	// year mod 400 is found by conditional subtraction of 400 * 2^k, k = 5 down to 0
	localparam int REDUCE_STEPS = 6;
	localparam int RED_IDX_W = 3;

	typedef struct packed {
		logic [MONTH_W-1:0] month_in;
		logic signed [DAY_IN_W-1:0] day_in;
		logic [YEAR_W-1:0] year_in;
		logic clamp_to_month_end;
	} in_item_t;

	typedef struct packed {
		logic [MONTH_W-1:0] month_out;
		logic [DAY_OUT_W-1:0] day_out;
		logic [YEAR_W-1:0] year_out;
		logic range_error;
	} out_item_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_REDUCE,
		ST_NORM
	} state_t;

	typedef struct packed {
		logic load;
		logic reduce;
		logic [RED_IDX_W-1:0] red_idx;
		logic step_back;
		logic step_fwd;
		logic clamp_day;
		logic finish;
	} cmd_t;

	typedef struct packed {
		logic day_le0;
		logic day_gt_len;
		logic clamp;
	} status_t;

	// subtrahend of one reduction step: 400 shifted left by (5 - step)
	function automatic logic [YEAR_W-1:0] red_const(input logic [RED_IDX_W-1:0] idx);
		logic [YEAR_W-1:0] r;
		r = CYCLE_LEN << (REDUCE_STEPS - 1 - int'(idx));
		return r;
	endfunction

	// leap test on the year's position inside the 400-year cycle
	function automatic logic is_leap(input logic [8:0] m400);
		logic r;
		r = (m400[1:0] == 2'b00) &&
			((m400 != CENTURY) && (m400 != 9'(2 * CENTURY)) && (m400 != 9'(3 * CENTURY)));
		return r;
	endfunction

	function automatic logic [DAY_OUT_W-1:0] month_len(input logic [MONTH_W-1:0] m,
		input logic leap);
		logic [DAY_OUT_W-1:0] r;
		case (m) inside
			MON_APR, MON_JUN, MON_SEP, MON_NOV: r = DAYS_SHORT;
			MON_FEB: r = leap ? DAYS_FEB_LEAP : DAYS_FEB;
			default: r = DAYS_LONG;
		endcase
		return r;
	endfunction

endpackage

/* rtl/cdn_if.sv */
// Valid/ready channel interfaces for the date normalizer requests and results.
// Depends on cdn_pkg for the payload structs.
interface cdn_in_if import cdn_pkg::*; ();
	logic valid;
	logic ready;
	in_item_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

interface cdn_out_if import cdn_pkg::*; ();
	logic valid;
	logic ready;
	out_item_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

/* rtl/cdn_ctrl.sv */
// Controller of the date normalizer: sequences load, mod-400 reduction,
// month steps, day clamp and result hand-off. Depends on cdn_pkg.
module cdn_ctrl import cdn_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic req_valid,
	output logic req_ready,
	output logic rsp_valid,
	input logic rsp_ready,
	input status_t status,
	output cmd_t cmd
);

	state_t state_q, state_d;
	logic [RED_IDX_W-1:0] red_cnt_q, red_cnt_d;
	logic rsp_valid_q, rsp_valid_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			red_cnt_q <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			red_cnt_q <= red_cnt_d;
			rsp_valid_q <= rsp_valid_d;
		end
	end

	always_comb begin
		logic slot_free;
		state_d = state_q;
		red_cnt_d = red_cnt_q;
		cmd = '0;
		cmd.red_idx = red_cnt_q;
		req_ready = 1'b0;
		slot_free = !rsp_valid_q || rsp_ready;
		rsp_valid_d = rsp_valid_q && !rsp_ready;

		unique case (state_q)
			ST_IDLE: begin
				req_ready = 1'b1;
				if (req_valid) begin
					cmd.load = 1'b1;
					red_cnt_d = '0;
					state_d = ST_REDUCE;
				end
			end
			ST_REDUCE: begin
				cmd.reduce = 1'b1;
				red_cnt_d = red_cnt_q + 1'b1;
				if (red_cnt_q == RED_IDX_W'(REDUCE_STEPS - 1)) begin
					state_d = ST_NORM;
				end
			end
			ST_NORM: begin
				if (status.day_le0) begin
					cmd.step_back = 1'b1;
				end else if (status.day_gt_len) begin
					if (status.clamp) begin
						cmd.clamp_day = 1'b1;
					end else begin
						cmd.step_fwd = 1'b1;
					end
				end else if (slot_free) begin
					cmd.finish = 1'b1;
					rsp_valid_d = 1'b1;
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	assign rsp_valid = rsp_valid_q;

endmodule

/* rtl/cdn_dp.sv */
// Datapath of the date normalizer: date registers, mod-400 year tracker,
// month-length logic and the result register. Depends on cdn_pkg.
module cdn_dp import cdn_pkg::*; (
	input logic clk,
	input in_item_t req_data,
	input cmd_t cmd,
	output status_t status,
	output out_item_t rsp_data
);

	logic [MONTH_W-1:0] month_q;
	logic signed [YEAR_RUN_W-1:0] year_q;
	logic signed [DAY_IN_W-1:0] day_q;
	logic [YEAR_W-1:0] m400_q;
	logic clamp_q;
	out_item_t rsp_q;

	logic [MONTH_W-1:0] month_ld;
	logic [MONTH_W-1:0] prev_month;
	logic [YEAR_W-1:0] prev_m400;
	logic [DAY_OUT_W-1:0] len_cur, len_prev;
	logic signed [DAY_IN_W-1:0] len_cur_s, len_prev_s;
	logic [YEAR_W-1:0] red_sub;
	out_item_t rsp_d;

	// out-of-range months snap to January or December
	always_comb begin
		if (req_data.month_in < MON_JAN) begin
			month_ld = MON_JAN;
		end else if (req_data.month_in > MON_DEC) begin
			month_ld = MON_DEC;
		end else begin
			month_ld = req_data.month_in;
		end
	end

	always_comb begin
		if (month_q == MON_JAN) begin
			prev_month = MON_DEC;
			prev_m400 = (m400_q == '0) ? CYCLE_LAST : m400_q - 1'b1;
		end else begin
			prev_month = month_q - 1'b1;
			prev_m400 = m400_q;
		end
	end

	assign len_cur = month_len(month_q, is_leap(m400_q[8:0]));
	assign len_prev = month_len(prev_month, is_leap(prev_m400[8:0]));
	assign len_cur_s = signed'({(DAY_IN_W - DAY_OUT_W)'(0), len_cur});
	assign len_prev_s = signed'({(DAY_IN_W - DAY_OUT_W)'(0), len_prev});
	assign red_sub = red_const(cmd.red_idx);

	assign status.day_le0 = day_q[DAY_IN_W-1] || (day_q == '0);
	assign status.day_gt_len = day_q > len_cur_s;
	assign status.clamp = clamp_q;

	// saturate when the year has left 0..9999
	always_comb begin
		rsp_d.range_error = 1'b0;
		rsp_d.month_out = month_q;
		rsp_d.day_out = day_q[DAY_OUT_W-1:0];
		rsp_d.year_out = year_q[YEAR_W-1:0];
		if (year_q[YEAR_RUN_W-1]) begin
			rsp_d.range_error = 1'b1;
			rsp_d.month_out = MON_JAN;
			rsp_d.day_out = DAY_FIRST;
			rsp_d.year_out = YEAR_MIN;
		end else if (year_q > signed'({(YEAR_RUN_W - YEAR_W)'(0), YEAR_MAX})) begin
			rsp_d.range_error = 1'b1;
			rsp_d.month_out = MON_DEC;
			rsp_d.day_out = DAYS_LONG;
			rsp_d.year_out = YEAR_MAX;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			month_q <= month_ld;
			day_q <= req_data.day_in;
			year_q <= signed'({(YEAR_RUN_W - YEAR_W)'(0), req_data.year_in});
			m400_q <= req_data.year_in;
			clamp_q <= req_data.clamp_to_month_end;
		end
		if (cmd.reduce && (m400_q >= red_sub)) begin
			m400_q <= m400_q - red_sub;
		end
		if (cmd.step_back) begin
			month_q <= prev_month;
			m400_q <= prev_m400;
			day_q <= day_q + len_prev_s;
			if (month_q == MON_JAN) begin
				year_q <= year_q - 1'b1;
			end
		end
		if (cmd.step_fwd) begin
			day_q <= day_q - len_cur_s;
			if (month_q == MON_DEC) begin
				month_q <= MON_JAN;
				year_q <= year_q + 1'b1;
				m400_q <= (m400_q == CYCLE_LAST) ? '0 : m400_q + 1'b1;
			end else begin
				month_q <= month_q + 1'b1;
			end
		end
		if (cmd.clamp_day) begin
			day_q <= len_cur_s;
		end
		if (cmd.finish) begin
			rsp_q <= rsp_d;
		end
	end

	assign rsp_data = rsp_q;

endmodule

/* rtl/calendar_date_normalizer_core.sv */
// Top level of the Gregorian date normalizer: controller plus datapath.
// Depends on cdn_pkg, cdn_if, cdn_ctrl and cdn_dp.
//
//   channel  dir  handshake            payload
//   req      in   req.valid/req.ready  month_in, day_in, year_in, clamp_to_month_end
//   rsp      out  rsp.valid/rsp.ready  month_out, day_out, year_out, range_error
//
// A request passes from acceptance to a result in the output register through
// a load step, the steps reducing the year mod 400, N month steps (one per
// cycle, through the month-length logic) and a finish step. N reaches about
// 1080 for the extreme day offsets; clamp mode adds a clamp step.
// One request is in work at a time; req.ready is high only while idle, and the
// next request is taken while a result still waits in the output register.
// A stalled result holds; the finish step waits until the output slot is free.
// arst_n clears the controller and the result valid flag; no clearing pass.
module calendar_date_normalizer_core import cdn_pkg::*; (
	input logic clk,
	input logic arst_n,
	cdn_in_if.sink req,
	cdn_out_if.source rsp
);

	cmd_t cmd;
	status_t status;

	// sequence the work of one request
	cdn_ctrl u_ctrl (
		.clk(clk),
		.arst_n(arst_n),
		.req_valid(req.valid),
		.req_ready(req.ready),
		.rsp_valid(rsp.valid),
		.rsp_ready(rsp.ready),
		.status(status),
		.cmd(cmd)
	);

	// hold the date under work and the result register
	cdn_dp u_dp (
		.clk(clk),
		.req_data(req.data),
		.cmd(cmd),
		.status(status),
		.rsp_data(rsp.data)
	);

endmodule

/* rtl/cdn_checker.sv */
// Port-level checks for the date normalizer, bound to the top level.
// Depends on cdn_pkg and calendar_date_normalizer_core.
module cdn_checker import cdn_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic req_valid,
	input logic req_ready,
	input logic rsp_valid,
	input logic rsp_ready,
	input out_item_t rsp_data
);

	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
		else $error("result changed while stalled");

	a_busy_after_req: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready |=> !req_ready)
		else $error("request taken while previous one in work");

	a_valid_date: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> (rsp_data.month_out >= MON_JAN) && (rsp_data.month_out <= MON_DEC) &&
			(rsp_data.day_out >= DAY_FIRST) && (rsp_data.year_out <= YEAR_MAX))
		else $error("result date out of range");

	a_month_len: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && ((rsp_data.month_out == MON_APR) || (rsp_data.month_out == MON_JUN) ||
			(rsp_data.month_out == MON_SEP) || (rsp_data.month_out == MON_NOV) ||
			(rsp_data.month_out == MON_FEB)) |->
			(rsp_data.day_out <= DAYS_SHORT) &&
			((rsp_data.month_out != MON_FEB) || (rsp_data.day_out <= DAYS_FEB_LEAP)))
		else $error("day beyond month end");

	a_sat_date: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_data.range_error |->
			((rsp_data.year_out == YEAR_MAX) && (rsp_data.month_out == MON_DEC) &&
			(rsp_data.day_out == DAYS_LONG)) ||
			((rsp_data.year_out == YEAR_MIN) && (rsp_data.month_out == MON_JAN) &&
			(rsp_data.day_out == DAY_FIRST)))
		else $error("saturated result not at a range end");

endmodule

bind calendar_date_normalizer_core cdn_checker u_cdn_checker (
	.clk(clk),
	.arst_n(arst_n),
	.req_valid(req.valid),
	.req_ready(req.ready),
	.rsp_valid(rsp.valid),
	.rsp_ready(rsp.ready),
	.rsp_data(rsp.data)
);
